/* hw/rtl/vaa_pkg.sv */
// Shared constants, control struct and arctangent table for the vector angle pipeline.
// No dependencies; imported by vaa_cordic_stage and vector_angle_atan2.
`default_nettype none

package vaa_pkg;

  // Default parameter values
  localparam int ROTATION_STEPS_DEF = 16;
  localparam int COORD_BITS_DEF     = 16;

  // Fixed-point layout
  localparam int GUARD_SHIFT = 24;          // datapath fraction bits
  localparam int TABLE_LEN   = 24;          // entries in the arctangent table
  localparam int IDX_W       = 5;           // table index width
  localparam int XW_HEAD     = 3;           // headroom bits for CORDIC gain and sign
  localparam int ACC_W       = 28;          // angle accumulator, units of 2^-24 rad
  localparam int ANGLE_W     = 16;          // output angle, units of 2^-13 rad
  localparam int ROUND_SHIFT = 11;
  localparam int OUT_Q_W     = ACC_W - ROUND_SHIFT;

  localparam logic [ACC_W-1:0] ACC_PI     = ACC_W'(52707179);
  localparam logic [ACC_W-1:0] ACC_TWO_PI = ACC_W'(105414357);
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1024);

  localparam logic [ANGLE_W-1:0] OUT_ZERO          = ANGLE_W'(0);
  localparam logic [ANGLE_W-1:0] OUT_HALF_PI       = ANGLE_W'(12868);
  localparam logic [ANGLE_W-1:0] OUT_PI            = ANGLE_W'(25736);
  localparam logic [ANGLE_W-1:0] OUT_THREE_HALF_PI = ANGLE_W'(38604);
  localparam logic [ANGLE_W-1:0] OUT_FULL_TURN     = ANGLE_W'(51472);

  // Control that travels alongside the datapath through every stage
  typedef struct packed {
    logic               valid;
    logic               special;     // axis-aligned or zero vector
    logic [ANGLE_W-1:0] spec_angle;  // answer for the special case
  } ctl_t;

  // atan(2^-i) * 2^24, rounded to nearest
  function automatic logic [ACC_W-1:0] micro_angle(input logic [IDX_W-1:0] idx);
    logic [ACC_W-1:0] a;
    case (idx)
      5'd0:    a = ACC_W'(13176795);
      5'd1:    a = ACC_W'(7778716);
      5'd2:    a = ACC_W'(4110060);
      5'd3:    a = ACC_W'(2086331);
      5'd4:    a = ACC_W'(1047214);
      5'd5:    a = ACC_W'(524117);
      5'd6:    a = ACC_W'(262123);
      5'd7:    a = ACC_W'(131069);
      5'd8:    a = ACC_W'(65536);
      5'd9:    a = ACC_W'(32768);
      5'd10:   a = ACC_W'(16384);
      5'd11:   a = ACC_W'(8192);
      5'd12:   a = ACC_W'(4096);
      5'd13:   a = ACC_W'(2048);
      5'd14:   a = ACC_W'(1024);
      5'd15:   a = ACC_W'(512);
      5'd16:   a = ACC_W'(256);
      5'd17:   a = ACC_W'(128);
      5'd18:   a = ACC_W'(64);
      5'd19:   a = ACC_W'(32);
      5'd20:   a = ACC_W'(16);
      5'd21:   a = ACC_W'(8);
      5'd22:   a = ACC_W'(4);
      5'd23:   a = ACC_W'(2);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/vaa_cordic_stage.sv */
// One registered CORDIC vectoring micro-rotation with a fixed shift.
// Depends on vaa_pkg (ctl_t, micro_angle, ACC_W).
`default_nettype none

module vaa_cordic_stage
  import vaa_pkg::*;
#(
  parameter int XW   = 44,
  parameter int STEP = 0
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire ctl_t                    ctl_i,
  input  wire logic signed [XW-1:0]    x_i,
  input  wire logic signed [XW-1:0]    y_i,
  input  wire logic signed [ACC_W-1:0] acc_i,
  output ctl_t                         ctl_o,
  output logic signed [XW-1:0]         x_o,
  output logic signed [XW-1:0]         y_o,
  output logic signed [ACC_W-1:0]      acc_o
);

  logic signed [ACC_W-1:0] ang;
  logic signed [XW-1:0]    xs, ys;
  logic signed [XW-1:0]    x_nxt, y_nxt;
  logic signed [ACC_W-1:0] acc_nxt;
  ctl_t                    ctl_r;
  logic signed [XW-1:0]    x_r, y_r;
  logic signed [ACC_W-1:0] acc_r;

  assign ang = micro_angle(IDX_W'(STEP));
  assign xs  = x_i >>> STEP;
  assign ys  = y_i >>> STEP;

  // Rotate towards y = 0, direction from the sign of y
  always_comb begin
    if (!y_i[XW-1]) begin
      x_nxt   = x_i + ys;
      y_nxt   = y_i - xs;
      acc_nxt = acc_i + ang;
    end else begin
      x_nxt   = x_i - ys;
      y_nxt   = y_i + xs;
      acc_nxt = acc_i - ang;
    end
  end

  // Valid bit under reset; payload is not reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_i.valid;
    end
    ctl_r.special    <= ctl_i.special;
    ctl_r.spec_angle <= ctl_i.spec_angle;
    x_r              <= x_nxt;
    y_r              <= y_nxt;
    acc_r            <= acc_nxt;
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign acc_o = acc_r;

endmodule

`default_nettype wire

/* hw/rtl/vector_angle_atan2.sv */
// Direction of (end - start) as an angle in [0, 2pi), units of 2^-13 rad.
// Registers from start to out_valid, in order: difference, pre-rotation,
// one register per CORDIC micro-rotation (ROTATION_STEPS, capped at the table length), wrap, rounding.
// Throughput: one transaction per cycle; busy is always low and out_valid is a strobe.
// Reset (rst_n low, synchronous) clears the valid bits only; datapath is not reset.
// Depends on vaa_pkg and vaa_cordic_stage.
`default_nettype none

module vector_angle_atan2
  import vaa_pkg::*;
#(
  parameter int ROTATION_STEPS = ROTATION_STEPS_DEF,
  parameter int COORD_BITS     = COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [COORD_BITS-1:0] in_start_x,
  input  wire logic signed [COORD_BITS-1:0] in_start_y,
  input  wire logic signed [COORD_BITS-1:0] in_end_x,
  input  wire logic signed [COORD_BITS-1:0] in_end_y,
  output logic                              out_valid,
  output logic [ANGLE_W-1:0]                out_angle
);

  localparam int STEPS = (ROTATION_STEPS < TABLE_LEN) ? ROTATION_STEPS : TABLE_LEN;
  localparam int DW    = COORD_BITS + 1;
  localparam int XW    = DW + GUARD_SHIFT + XW_HEAD;

  // ---------------------------------------------------------------- difference
  logic                 a_valid_r;
  logic signed [DW-1:0] dx_r, dy_r;
  logic signed [DW-1:0] dx_nxt, dy_nxt;

  assign busy   = 1'b0;
  assign dx_nxt = DW'(in_end_x) - DW'(in_start_x);
  assign dy_nxt = DW'(in_end_y) - DW'(in_start_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
  end

  // ---------------------------------------------------------- pre-rotation
  // Left half plane is turned by pi; axis cases resolved here.
  ctl_t                    b_ctl_nxt, b_ctl_r;
  logic signed [DW-1:0]    xm, ym;
  logic signed [XW-1:0]    b_x_nxt, b_y_nxt, b_x_r, b_y_r;
  logic signed [ACC_W-1:0] b_acc_nxt, b_acc_r;

  always_comb begin
    xm        = dx_r[DW-1] ? -dx_r : dx_r;
    ym        = dx_r[DW-1] ? -dy_r : dy_r;
    b_x_nxt   = {{XW_HEAD{xm[DW-1]}}, xm, {GUARD_SHIFT{1'b0}}};
    b_y_nxt   = {{XW_HEAD{ym[DW-1]}}, ym, {GUARD_SHIFT{1'b0}}};
    b_acc_nxt = dx_r[DW-1] ? ACC_PI : '0;

    b_ctl_nxt.valid      = a_valid_r;
    b_ctl_nxt.special    = 1'b0;
    b_ctl_nxt.spec_angle = OUT_ZERO;
    if (dx_r == '0) begin
      b_ctl_nxt.special = 1'b1;
      if (dy_r == '0) begin
        b_ctl_nxt.spec_angle = OUT_ZERO;
      end else if (dy_r[DW-1]) begin
        b_ctl_nxt.spec_angle = OUT_THREE_HALF_PI;
      end else begin
        b_ctl_nxt.spec_angle = OUT_HALF_PI;
      end
    end else if (dy_r == '0) begin
      b_ctl_nxt.special    = 1'b1;
      b_ctl_nxt.spec_angle = dx_r[DW-1] ? OUT_PI : OUT_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_ctl_r.valid <= 1'b0;
    end else begin
      b_ctl_r.valid <= b_ctl_nxt.valid;
    end
    b_ctl_r.special    <= b_ctl_nxt.special;
    b_ctl_r.spec_angle <= b_ctl_nxt.spec_angle;
    b_x_r              <= b_x_nxt;
    b_y_r              <= b_y_nxt;
    b_acc_r            <= b_acc_nxt;
  end

  // ----------------------------------------------------------- CORDIC chain
  ctl_t                    s_ctl [STEPS+1];
  logic signed [XW-1:0]    s_x   [STEPS+1];
  logic signed [XW-1:0]    s_y   [STEPS+1];
  logic signed [ACC_W-1:0] s_acc [STEPS+1];

  assign s_ctl[0] = b_ctl_r;
  assign s_x[0]   = b_x_r;
  assign s_y[0]   = b_y_r;
  assign s_acc[0] = b_acc_r;

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    vaa_cordic_stage #(
      .XW   (XW),
      .STEP (g)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (s_ctl[g]),
      .x_i   (s_x[g]),
      .y_i   (s_y[g]),
      .acc_i (s_acc[g]),
      .ctl_o (s_ctl[g+1]),
      .x_o   (s_x[g+1]),
      .y_o   (s_y[g+1]),
      .acc_o (s_acc[g+1])
    );
  end

  // ------------------------------------------------------------ wrap to 0..2pi
  ctl_t                    w_ctl_r;
  logic signed [ACC_W-1:0] acc_last, w_sum;
  logic        [ACC_W-1:0] w_acc_nxt, w_acc_r;

  assign acc_last = s_acc[STEPS];

  always_comb begin
    w_sum = acc_last[ACC_W-1] ? acc_last + $signed(ACC_TWO_PI) : acc_last;
    // clamp anything still negative to zero
    w_acc_nxt = w_sum[ACC_W-1] ? '0 : w_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_ctl_r.valid <= 1'b0;
    end else begin
      w_ctl_r.valid <= s_ctl[STEPS].valid;
    end
    w_ctl_r.special    <= s_ctl[STEPS].special;
    w_ctl_r.spec_angle <= s_ctl[STEPS].spec_angle;
    w_acc_r            <= w_acc_nxt;
  end

  // ------------------------------------------------------ round and output
  logic [ACC_W-1:0]   rnd;
  logic [OUT_Q_W-1:0] q;
  logic [ANGLE_W-1:0] angle_nxt;
  logic               out_valid_r;
  logic [ANGLE_W-1:0] out_angle_r;

  always_comb begin
    rnd = w_acc_r + ROUND_HALF;
    q   = rnd[ACC_W-1:ROUND_SHIFT];
    if (w_ctl_r.special) begin
      angle_nxt = w_ctl_r.spec_angle;
    end else if (q >= OUT_Q_W'(OUT_FULL_TURN)) begin
      angle_nxt = OUT_ZERO;  // rounded up to a full turn
    end else begin
      angle_nxt = q[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= w_ctl_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_angle_r <= angle_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_angle = out_angle_r;

endmodule

`default_nettype wire

/* verif/vector_angle_atan2_test.sv */
// Self-checking testbench for vector_angle_atan2: streams point pairs and checks each angle.
// Holds its own CORDIC angle predictor; depends on vaa_pkg and the vector_angle_atan2 RTL.
`timescale 1ns / 100ps

module vector_angle_atan2_test;
  import vaa_pkg::*;

  localparam int COORD_W    = COORD_BITS_DEF;
  localparam int STEPS      = ROTATION_STEPS_DEF;
  localparam int TAIL_WAIT  = STEPS + 12;
  localparam int PRINT_CAP  = 30;

  // One point-pair query and the angle it should produce
  typedef struct {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic [ANGLE_W-1:0]        angle;
  } angle_query_t;

  logic                      clk;
  logic                      rst_n      = 1'b0;
  logic                      start      = 1'b0;
  logic                      busy;
  logic signed [COORD_W-1:0] in_start_x = '0;
  logic signed [COORD_W-1:0] in_start_y = '0;
  logic signed [COORD_W-1:0] in_end_x   = '0;
  logic signed [COORD_W-1:0] in_end_y   = '0;
  logic                      out_valid;
  logic [ANGLE_W-1:0]        out_angle;

  angle_query_t pending_angles[$];
  int           idle_pct       = 0;
  int           queries_sent   = 0;
  int           directed_sent  = 0;
  int           angles_checked = 0;
  int           error_count    = 0;

  // atan(2^-i) in units of 2^-24 rad
  longint atan_step [TABLE_LEN] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  logic signed [COORD_W-1:0] corner_vals [5] = '{
    -16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd32767
  };

  vector_angle_atan2 u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .out_valid  (out_valid),
    .out_angle  (out_angle)
  );

  // Clock, 12 ns period
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: far beyond the slowest legitimate run
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Direction of (end - start) in units of 2^-13 rad, full circle
  function automatic logic [ANGLE_W-1:0] predict_angle(input angle_query_t q);
    longint dx, dy, x, y, xs, ys, acc, rounded;
    int     i;
    dx = longint'(q.end_x) - longint'(q.start_x);
    dy = longint'(q.end_y) - longint'(q.start_y);
    // axis-aligned and zero vectors bypass the CORDIC
    if (dx == 0) begin
      if (dy > 0) return OUT_HALF_PI;
      if (dy < 0) return OUT_THREE_HALF_PI;
      return OUT_ZERO;
    end
    if (dy == 0) return (dx > 0) ? OUT_ZERO : OUT_PI;
    // left half plane: turn by pi before vectoring
    if (dx < 0) begin
      x   = (-dx) <<< GUARD_SHIFT;
      y   = (-dy) <<< GUARD_SHIFT;
      acc = longint'(ACC_PI);
    end else begin
      x   = dx <<< GUARD_SHIFT;
      y   = dy <<< GUARD_SHIFT;
      acc = 0;
    end
    for (i = 0; i < STEPS && i < TABLE_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x   = x + ys;
        y   = y - xs;
        acc = acc + atan_step[i];
      end else begin
        x   = x - ys;
        y   = y + xs;
        acc = acc - atan_step[i];
      end
    end
    if (acc < 0) acc = acc + longint'(ACC_TWO_PI);
    if (acc < 0) acc = 0;
    rounded = (acc + longint'(ROUND_HALF)) >>> ROUND_SHIFT;
    // rounding up to a full turn wraps to zero
    if (rounded >= longint'(OUT_FULL_TURN)) return OUT_ZERO;
    return ANGLE_W'(rounded);
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_CAP) $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  // Send one query; returns at the edge where the transaction was taken
  task automatic send_query(input logic signed [COORD_W-1:0] sx, sy, ex, ey);
    angle_query_t q;
    bit           taken;
    // each cycle is idle with probability idle_pct percent
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    in_start_x <= sx;
    in_start_y <= sy;
    in_end_x   <= ex;
    in_end_y   <= ey;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = (busy === 1'b0);
      @(posedge clk);
    end
    q.start_x = sx;
    q.start_y = sy;
    q.end_x   = ex;
    q.end_y   = ey;
    q.angle   = predict_angle(q);
    pending_angles.push_back(q);
    queries_sent++;
  endtask

  // Result checker: out_valid is a one-cycle strobe, sampled mid-cycle
  always @(negedge clk) begin : angle_check
    angle_query_t q;
    if (rst_n) begin
      if ($isunknown(out_valid)) begin
        report_mismatch("out_valid unknown");
      end else if (out_valid) begin
        if (pending_angles.size() == 0) begin
          report_mismatch($sformatf("unexpected angle %0d", out_angle));
        end else begin
          q = pending_angles.pop_front();
          angles_checked++;
          if (out_angle !== q.angle)
            report_mismatch($sformatf("(%0d,%0d)->(%0d,%0d) angle %0d, want %0d",
                                      q.start_x, q.start_y, q.end_x, q.end_y,
                                      out_angle, q.angle));
        end
      end
    end
  end

  // Zero vector and the four axis directions, at small and full span
  task automatic test_axis_and_zero();
    send_query(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_query(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_query(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_query(16'sd0, 16'sd0, 16'sd0, 16'sd1);
    send_query(16'sd5, -16'sd32768, 16'sd5, 16'sd32767);
    send_query(16'sd0, 16'sd0, 16'sd0, -16'sd1);
    send_query(-16'sd7, 16'sd32767, -16'sd7, -16'sd32768);
    send_query(16'sd0, 16'sd0, 16'sd1, 16'sd0);
    send_query(-16'sd32768, 16'sd5, 16'sd32767, 16'sd5);
    send_query(16'sd0, 16'sd0, -16'sd1, 16'sd0);
    send_query(16'sd32767, -16'sd3, -16'sd32768, -16'sd3);
    directed_sent += 11;
  endtask

  // Diagonals in each quadrant, corners of the coordinate range, near-wrap cases
  task automatic test_quadrants_and_wrap();
    send_query(16'sd0, 16'sd0, 16'sd1, 16'sd1);
    send_query(16'sd0, 16'sd0, -16'sd1, 16'sd1);
    send_query(16'sd0, 16'sd0, -16'sd1, -16'sd1);
    send_query(16'sd0, 16'sd0, 16'sd1, -16'sd1);
    send_query(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768);
    send_query(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
    send_query(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
    send_query(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
    // just below a full turn: rounds up and wraps to zero
    send_query(-16'sd32768, 16'sd0, 16'sd32767, -16'sd1);
    send_query(16'sd0, 16'sd1, 16'sd32767, 16'sd0);
    // just either side of pi
    send_query(16'sd32767, 16'sd0, -16'sd32768, 16'sd1);
    send_query(16'sd32767, 16'sd1, -16'sd32768, 16'sd0);
    // steep vectors near the vertical axis
    send_query(16'sd0, -16'sd32768, 16'sd1, 16'sd32767);
    send_query(16'sd0, 16'sd32767, -16'sd1, -16'sd32768);
    directed_sent += 14;
  endtask

  // Random traffic: wide vectors, short hops, axis and near-axis, diagonals, corners
  task automatic test_random_traffic(input int count, input int pct);
    logic signed [COORD_W-1:0] sx, sy, ex, ey;
    int                        kind, mag;
    idle_pct = pct;
    repeat (count) begin
      sx = COORD_W'($urandom);
      sy = COORD_W'($urandom);
      ex = COORD_W'($urandom);
      ey = COORD_W'($urandom);
      kind = $urandom_range(9);
      case (kind)
        4, 5: begin
          ex = COORD_W'(int'(sx) + int'($urandom_range(600)) - 300);
          ey = COORD_W'(int'(sy) + int'($urandom_range(600)) - 300);
        end
        6: begin
          if ($urandom_range(1)) ex = sx;
          else ey = sy;
        end
        7: begin
          mag = $urandom_range(1, 3);
          if ($urandom_range(1)) ey = COORD_W'(int'(sy) + ($urandom_range(1) ? mag : -mag));
          else ex = COORD_W'(int'(sx) + ($urandom_range(1) ? mag : -mag));
        end
        8: begin
          mag = $urandom_range(1, 16000);
          sx  = COORD_W'(int'($urandom_range(32000)) - 16000);
          sy  = COORD_W'(int'($urandom_range(32000)) - 16000);
          ex  = COORD_W'(int'(sx) + ($urandom_range(1) ? mag : -mag));
          ey  = COORD_W'(int'(sy) + ($urandom_range(1) ? mag : -mag));
        end
        9: begin
          sx = corner_vals[$urandom_range(4)];
          sy = corner_vals[$urandom_range(4)];
          ex = corner_vals[$urandom_range(4)];
          ey = corner_vals[$urandom_range(4)];
        end
        default: ;
      endcase
      send_query(sx, sy, ex, ey);
    end
  endtask

  // Test sequence
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_axis_and_zero();
    test_quadrants_and_wrap();
    test_random_traffic(140, 0);
    test_random_traffic(130, 55);
    test_random_traffic(130, 26);
    start <= 1'b0;

    // drain the pipeline, then give it time to show any stray result
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("sent %0d point pairs (%0d directed), checked %0d angles", queries_sent,
             directed_sent, angles_checked);
    $display("sender idle: none, 55%% and 26%% of cycles; %0d mismatches", error_count);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
